[hdl/qvr_pkg.sv]
package qvr_pkg;

    localparam int QUAT_W      = 32;
    localparam int VEC_W       = 48;
    localparam int PROD_W      = 64;
    localparam int N2_W        = 65;
    localparam int MAT_W       = 66;
    localparam int M_LO_W      = 33;
    localparam int V_LO_W      = 24;
    localparam int MV_W        = 114;
    localparam int ACC_W       = 116;
    localparam int TOP_W       = 118;
    localparam int DEN_W       = 66;
    localparam int QUO_W       = 49;
    localparam int PR_W        = DEN_W + QUO_W;
    localparam int IN_TDATA_W  = 272;
    localparam int OUT_TDATA_W = 144;

    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [MAT_W-1:0]  t_mat;
    typedef logic signed [MV_W-1:0]   t_mv;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic        [N2_W-1:0]   t_n2;

    typedef struct packed {
        logic                  vld;
        logic [2:0]            neg;
        logic [DEN_W-1:0]      den;
        logic [2:0][PR_W-1:0]  pr;
    } t_div_st;

endpackage

[hdl/qvr_coef.sv]
module qvr_coef (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_vld,
    input  qvr_pkg::t_quat i_w,
    input  qvr_pkg::t_quat i_x,
    input  qvr_pkg::t_quat i_y,
    input  qvr_pkg::t_quat i_z,
    input  qvr_pkg::t_vec  i_vec [3],
    output logic           o_vld,
    output qvr_pkg::t_mat  o_mat [9],
    output qvr_pkg::t_n2   o_n2,
    output qvr_pkg::t_vec  o_vec [3]
);

    logic           r_vld_a;
    qvr_pkg::t_prod r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    qvr_pkg::t_vec  r_vec_a [3];

    logic           r_vld_b;
    qvr_pkg::t_mat  r_mat [9];
    qvr_pkg::t_n2   r_n2;
    qvr_pkg::t_vec  r_vec_b [3];

    qvr_pkg::t_mat  n_mat [9];
    qvr_pkg::t_n2   n_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_ce) begin
            r_vld_a <= i_vld;
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_vec_a <= i_vec;
        end
    end

    always_comb begin
        qvr_pkg::t_mat t01, t02, t10, t12, t20, t21;
        t01 = qvr_pkg::MAT_W'(r_xy) - qvr_pkg::MAT_W'(r_wz);
        t02 = qvr_pkg::MAT_W'(r_xz) + qvr_pkg::MAT_W'(r_wy);
        t10 = qvr_pkg::MAT_W'(r_xy) + qvr_pkg::MAT_W'(r_wz);
        t12 = qvr_pkg::MAT_W'(r_yz) - qvr_pkg::MAT_W'(r_wx);
        t20 = qvr_pkg::MAT_W'(r_xz) - qvr_pkg::MAT_W'(r_wy);
        t21 = qvr_pkg::MAT_W'(r_yz) + qvr_pkg::MAT_W'(r_wx);
        n_mat[0] = qvr_pkg::MAT_W'(r_ww) + qvr_pkg::MAT_W'(r_xx)
                 - qvr_pkg::MAT_W'(r_yy) - qvr_pkg::MAT_W'(r_zz);
        n_mat[1] = t01 + t01;
        n_mat[2] = t02 + t02;
        n_mat[3] = t10 + t10;
        n_mat[4] = qvr_pkg::MAT_W'(r_ww) + qvr_pkg::MAT_W'(r_yy)
                 - qvr_pkg::MAT_W'(r_xx) - qvr_pkg::MAT_W'(r_zz);
        n_mat[5] = t12 + t12;
        n_mat[6] = t20 + t20;
        n_mat[7] = t21 + t21;
        n_mat[8] = qvr_pkg::MAT_W'(r_ww) + qvr_pkg::MAT_W'(r_zz)
                 - qvr_pkg::MAT_W'(r_xx) - qvr_pkg::MAT_W'(r_yy);
        n_n2 = qvr_pkg::N2_W'($unsigned(r_ww)) + qvr_pkg::N2_W'($unsigned(r_xx))
             + qvr_pkg::N2_W'($unsigned(r_yy)) + qvr_pkg::N2_W'($unsigned(r_zz));
        // zero quaternion: substitute identity with unit norm
        if (n_n2 == '0) begin
            for (int e = 0; e < 9; e++) begin
                n_mat[e] = (e % 4 == 0) ? qvr_pkg::MAT_W'(1) : '0;
            end
            n_n2 = qvr_pkg::N2_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_ce) begin
            r_vld_b <= r_vld_a;
            r_mat   <= n_mat;
            r_n2    <= n_n2;
            r_vec_b <= r_vec_a;
        end
    end

    assign o_vld = r_vld_b;
    assign o_mat = r_mat;
    assign o_n2  = r_n2;
    assign o_vec = r_vec_b;

endmodule

[hdl/qvr_matvec.sv]
module qvr_matvec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  qvr_pkg::t_mat i_mat [9],
    input  qvr_pkg::t_n2  i_n2,
    input  qvr_pkg::t_vec i_vec [3],
    output logic          o_vld,
    output qvr_pkg::t_acc o_acc [3],
    output qvr_pkg::t_n2  o_n2
);

    localparam int LL_W = qvr_pkg::M_LO_W + qvr_pkg::V_LO_W + 2;
    localparam int LH_W = qvr_pkg::M_LO_W + 1 + qvr_pkg::VEC_W - qvr_pkg::V_LO_W;
    localparam int HL_W = qvr_pkg::MAT_W - qvr_pkg::M_LO_W + qvr_pkg::V_LO_W + 1;
    localparam int HH_W = qvr_pkg::MAT_W - qvr_pkg::M_LO_W + qvr_pkg::VEC_W
                          - qvr_pkg::V_LO_W;

    logic                    r_vld_c, r_vld_d, r_vld_e;
    logic signed [LL_W-1:0]  r_ll [9];
    logic signed [LH_W-1:0]  r_lh [9];
    logic signed [HL_W-1:0]  r_hl [9];
    logic signed [HH_W-1:0]  r_hh [9];
    qvr_pkg::t_n2            r_n2_c, r_n2_d, r_n2_e;
    qvr_pkg::t_mv            r_prod [9];
    qvr_pkg::t_acc           r_acc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (i_ce) begin
            r_vld_c <= i_vld;
            r_n2_c  <= i_n2;
            for (int e = 0; e < 9; e++) begin
                r_ll[e] <= $signed({1'b0, i_mat[e][qvr_pkg::M_LO_W-1:0]})
                         * $signed({1'b0, i_vec[e%3][qvr_pkg::V_LO_W-1:0]});
                r_lh[e] <= $signed({1'b0, i_mat[e][qvr_pkg::M_LO_W-1:0]})
                         * $signed(i_vec[e%3][qvr_pkg::VEC_W-1:qvr_pkg::V_LO_W]);
                r_hl[e] <= $signed(i_mat[e][qvr_pkg::MAT_W-1:qvr_pkg::M_LO_W])
                         * $signed({1'b0, i_vec[e%3][qvr_pkg::V_LO_W-1:0]});
                r_hh[e] <= $signed(i_mat[e][qvr_pkg::MAT_W-1:qvr_pkg::M_LO_W])
                         * $signed(i_vec[e%3][qvr_pkg::VEC_W-1:qvr_pkg::V_LO_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
        end else if (i_ce) begin
            r_vld_d <= r_vld_c;
            r_n2_d  <= r_n2_c;
            for (int e = 0; e < 9; e++) begin
                r_prod[e] <= qvr_pkg::MV_W'(r_ll[e])
                           + (qvr_pkg::MV_W'(r_lh[e]) <<< qvr_pkg::V_LO_W)
                           + (qvr_pkg::MV_W'(r_hl[e]) <<< qvr_pkg::M_LO_W)
                           + (qvr_pkg::MV_W'(r_hh[e]) <<< (qvr_pkg::M_LO_W
                                                          + qvr_pkg::V_LO_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else if (i_ce) begin
            r_vld_e <= r_vld_d;
            r_n2_e  <= r_n2_d;
            for (int r = 0; r < 3; r++) begin
                r_acc[r] <= qvr_pkg::ACC_W'(r_prod[3*r])
                          + qvr_pkg::ACC_W'(r_prod[3*r+1])
                          + qvr_pkg::ACC_W'(r_prod[3*r+2]);
            end
        end
    end

    assign o_vld = r_vld_e;
    assign o_acc = r_acc;
    assign o_n2  = r_n2_e;

endmodule

[hdl/qvr_div.sv]
module qvr_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  qvr_pkg::t_acc i_acc [3],
    input  qvr_pkg::t_n2  i_n2,
    output logic          o_vld,
    output qvr_pkg::t_vec o_rot [3]
);

    qvr_pkg::t_div_st r_st [qvr_pkg::QUO_W+1];
    qvr_pkg::t_div_st n_st [qvr_pkg::QUO_W+1];
    logic             r_vld_o;
    qvr_pkg::t_vec    r_rot [3];

    always_comb begin
        logic [qvr_pkg::ACC_W-1:0] mag;
        logic [qvr_pkg::TOP_W-1:0] top;
        logic [qvr_pkg::DEN_W:0]   t;
        logic                      ge;
        logic [qvr_pkg::DEN_W:0]   rem;
        n_st[0].vld = i_vld;
        n_st[0].den = {i_n2, 1'b0};
        for (int c = 0; c < 3; c++) begin
            n_st[0].neg[c] = i_acc[c][qvr_pkg::ACC_W-1];
            mag = n_st[0].neg[c] ? $unsigned(-i_acc[c]) : $unsigned(i_acc[c]);
            top = qvr_pkg::TOP_W'({mag, 1'b0}) + qvr_pkg::TOP_W'(i_n2);
            n_st[0].pr[c] = top[qvr_pkg::PR_W-1:0];
        end
        for (int g = 0; g < qvr_pkg::QUO_W; g++) begin
            n_st[g+1] = r_st[g];
            for (int c = 0; c < 3; c++) begin
                t   = {r_st[g].pr[c][qvr_pkg::PR_W-1:qvr_pkg::QUO_W],
                       r_st[g].pr[c][qvr_pkg::QUO_W-1]};
                ge  = (t >= {1'b0, r_st[g].den});
                rem = ge ? (t - {1'b0, r_st[g].den}) : t;
                n_st[g+1].pr[c] = {rem[qvr_pkg::DEN_W-1:0],
                                   r_st[g].pr[c][qvr_pkg::QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g <= qvr_pkg::QUO_W; g++) begin
                r_st[g].vld <= 1'b0;
            end
        end else if (i_ce) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [qvr_pkg::QUO_W-1:0] q;
        logic [qvr_pkg::QUO_W-1:0] lim;
        logic [qvr_pkg::QUO_W-1:0] clip;
        logic [qvr_pkg::QUO_W-1:0] val;
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (i_ce) begin
            r_vld_o <= r_st[qvr_pkg::QUO_W].vld;
            for (int c = 0; c < 3; c++) begin
                q    = r_st[qvr_pkg::QUO_W].pr[c][qvr_pkg::QUO_W-1:0];
                lim  = (qvr_pkg::QUO_W'(1) << (qvr_pkg::VEC_W - 1))
                     - (r_st[qvr_pkg::QUO_W].neg[c] ? qvr_pkg::QUO_W'(0)
                                                    : qvr_pkg::QUO_W'(1));
                clip = (q > lim) ? lim : q;
                val  = r_st[qvr_pkg::QUO_W].neg[c] ? (~clip + qvr_pkg::QUO_W'(1)) : clip;
                r_rot[c] <= val[qvr_pkg::VEC_W-1:0];
            end
        end
    end

    assign o_vld = r_vld_o;
    assign o_rot = r_rot;

endmodule

[hdl/quaternion_vector_rotate_core.sv]
// Rotates a Q32.16 3-vector by a Q4.28 quaternion that need not be normalized:
// each output is (M v)/|q|^2 rounded to nearest (ties away from zero) and
// saturated to 48 bits; an all-zero quaternion passes the vector unchanged.
// One item per clock while the output is not stalled; the stages, in order,
// are the quaternion products and rotation matrix, the split matrix-vector
// multiply, the division setup, the one-bit-per-stage long division and the
// saturating output register. A stall on the output holds the whole pipeline.
module quaternion_vector_rotate_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    input  logic [qvr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [qvr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic          ce;
    logic          vld_b, vld_e;
    qvr_pkg::t_vec vec_in [3];
    qvr_pkg::t_mat mat [9];
    qvr_pkg::t_n2  n2_b, n2_e;
    qvr_pkg::t_vec vec_b [3];
    qvr_pkg::t_acc acc [3];
    qvr_pkg::t_vec rot [3];

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    assign vec_in[0] = s_axis_tdata[175:128];
    assign vec_in[1] = s_axis_tdata[223:176];
    assign vec_in[2] = s_axis_tdata[271:224];

    qvr_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_axis_tvalid),
        .i_w     (s_axis_tdata[31:0]),
        .i_x     (s_axis_tdata[63:32]),
        .i_y     (s_axis_tdata[95:64]),
        .i_z     (s_axis_tdata[127:96]),
        .i_vec   (vec_in),
        .o_vld   (vld_b),
        .o_mat   (mat),
        .o_n2    (n2_b),
        .o_vec   (vec_b)
    );

    qvr_matvec u_matvec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (vld_b),
        .i_mat   (mat),
        .i_n2    (n2_b),
        .i_vec   (vec_b),
        .o_vld   (vld_e),
        .o_acc   (acc),
        .o_n2    (n2_e)
    );

    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (vld_e),
        .i_acc   (acc),
        .i_n2    (n2_e),
        .o_vld   (m_axis_tvalid),
        .o_rot   (rot)
    );

    assign m_axis_tdata = {rot[2], rot[1], rot[0]};

endmodule
